[rtl/pfba_pkg.sv]
`timescale 1ns / 1ps
package pfba_pkg;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  localparam logic REG_RESERVED = 1'b0;

  localparam int PAGE_SHIFT = 12;
  localparam int CFG_W      = 19;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [47:0] free_address;
  } req_t;

  typedef struct packed {
    logic [29:0] page_address;
    logic [1:0]  status;
    logic [18:0] free_count;
  } rsp_t;

  function automatic logic [5:0] lowest_set(input logic [63:0] v);
    logic [5:0] r;
    r = 6'd0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) begin
        r = 6'(i);
      end
    end
    return r;
  endfunction

endpackage

[rtl/page_frame_bitmap_allocator.sv]
`timescale 1ns / 1ps
// First-fit page frame allocator, one used bit per 4 KiB frame.
// Command channel: a beat is taken when start is high and busy is low.
// Opcodes: init (mark frames below reserved_frames used, rest free),
// alloc (lowest free frame at or above reserved_frames), free (by address).
// Every command gives one result beat on response, flagged by done for a
// single cycle in which busy is already low, so the next command can go in
// then; the receiver cannot stall, so it must take the beat that cycle.
// The bitmap sits in a RAM of 64-bit words; a second RAM holds one "word
// full" bit per bitmap word and steers the alloc search.
// Steps, start accepted to done:
//   free: bitmap read-modify-write, then summary update; ends after the
//     read when the frame is already free;
//   alloc: first word searched, then summary update if it had room; else
//     summary words scanned (at most NUM_FRAMES/4096, rounded up; 64 at the
//     default size), ending there if none has room, else the word found
//     read, then summary update; init: one bitmap word written per cycle;
//   unused opcode, or alloc/free settled from the command: answered from idle.
// Reset runs the same sweep with no reserved frames: busy stays high until
// every bitmap word is written, and no result is given.
// APB register at byte address 0 holds reserved_frames, sampled per command.
module page_frame_bitmap_allocator #(
  parameter int NUM_FRAMES = 262144
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  pfba_pkg::req_t request,
  output logic           done,
  output pfba_pkg::rsp_t response,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import pfba_pkg::*;

  localparam int WORDS = (NUM_FRAMES + 63) / 64;
  localparam int SW    = (WORDS + 63) / 64;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SAW   = (SW > 1) ? $clog2(SW) : 1;
  localparam int FRW   = WAW + 6;
  localparam int CW    = $clog2(NUM_FRAMES + 1);
  localparam logic [63:0] PAD_MASK = (NUM_FRAMES % 64 == 0) ? 64'd0 :
                                     ~((64'd1 << (NUM_FRAMES % 64)) - 64'd1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_AWORD = 3'd2;
  localparam logic [2:0] S_ASUM  = 3'd3;
  localparam logic [2:0] S_AHIT  = 3'd4;
  localparam logic [2:0] S_SUMRD = 3'd5;
  localparam logic [2:0] S_FWORD = 3'd6;

  logic [2:0]     state;
  logic [WAW-1:0] idx;
  logic [SAW-1:0] sidx;
  logic           first;
  logic [WAW-1:0] wreg;
  logic [FRW-1:0] frame;
  logic           full;
  logic           sum_set;
  logic [1:0]     op;
  logic           report;
  logic [CW-1:0]  count;
  logic [CW-1:0]  eff;
  logic [63:0]    acc;

  logic [18:0]    reserved_frames;
  logic [CW-1:0]  eff_now;
  logic [35:0]    free_frame;
  logic           free_ok;

  logic           bm_we;
  logic [WAW-1:0] bm_waddr;
  logic [63:0]    bm_wdata;
  logic [WAW-1:0] bm_raddr;
  logic [63:0]    bm_rdata;
  logic           sm_we;
  logic [SAW-1:0] sm_waddr;
  logic [63:0]    sm_wdata;
  logic [SAW-1:0] sm_raddr;
  logic [63:0]    sm_rdata;

  logic [63:0]    wmask;
  logic [63:0]    wavail;
  logic [5:0]     wb;
  logic           whit;
  logic [63:0]    set_word;
  logic [63:0]    clr_word;
  logic           fbit;
  logic [63:0]    smask;
  logic [63:0]    savail;
  logic [5:0]     sb;
  logic           shit;

  logic [5:0]     idx_lo;
  logic           idx_last;
  logic [63:0]    init_word;
  logic           init_full;
  logic [63:0]    sum_init;
  logic [5:0]     wbit;
  logic [CW-1:0]  count_upd;

  pfba_cfg u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .reserved_frames (reserved_frames)
  );

  pfba_ram #(.WIDTH(64), .DEPTH(WORDS)) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  pfba_ram #(.WIDTH(64), .DEPTH(SW)) u_summary (
    .clk   (clk),
    .we    (sm_we),
    .waddr (sm_waddr),
    .wdata (sm_wdata),
    .raddr (sm_raddr),
    .rdata (sm_rdata)
  );

  assign busy = (state != S_IDLE);

  assign eff_now    = (32'(reserved_frames) > 32'(NUM_FRAMES)) ? CW'(NUM_FRAMES)
                                                               : CW'(reserved_frames);
  assign free_frame = request.free_address[47:PAGE_SHIFT];
  assign free_ok    = 64'(free_frame) < 64'(NUM_FRAMES);

  // bitmap word search
  assign wmask    = (state == S_AWORD) ? (~64'd0 << frame[5:0]) : ~64'd0;
  assign wavail   = ~bm_rdata & wmask;
  assign wb       = lowest_set(wavail);
  assign whit     = |wavail;
  assign set_word = bm_rdata | (64'd1 << wb);
  assign clr_word = bm_rdata & ~(64'd1 << frame[5:0]);
  assign fbit     = bm_rdata[frame[5:0]];

  // summary search; first word skips entries at or below the start word
  assign smask  = first ? ((~64'd0 << 6'(wreg)) << 1) : ~64'd0;
  assign savail = ~sm_rdata & smask;
  assign sb     = lowest_set(savail);
  assign shit   = |savail;

  // init sweep
  assign idx_lo   = 6'(idx);
  assign idx_last = (32'(idx) == 32'(WORDS - 1));
  always_comb begin
    init_word = 64'd0;
    if (32'(idx) < 32'(eff >> 6)) begin
      init_word = ~64'd0;
    end else if (32'(idx) == 32'(eff >> 6)) begin
      init_word = (64'd1 << eff[5:0]) - 64'd1;
    end
    if (idx_last) begin
      init_word = init_word | PAD_MASK;
    end
  end
  assign init_full = &init_word;
  assign sum_init  = acc | (64'(init_full) << idx_lo) |
                     (idx_last ? ~((64'd2 << idx_lo) - 64'd1) : 64'd0);

  assign wbit      = 6'(wreg);
  assign count_upd = (op == OP_ALLOC) ? count - 1'b1 : count + 1'b1;

  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = wreg;
    bm_wdata = set_word;
    bm_raddr = wreg;
    sm_we    = 1'b0;
    sm_waddr = SAW'(wreg >> 6);
    sm_wdata = sm_rdata;
    sm_raddr = SAW'(wreg >> 6);
    case (state)
      S_IDLE: begin
        bm_raddr = (request.opcode == OP_FREE) ? WAW'(free_frame >> 6)
                                               : WAW'(eff_now >> 6);
      end
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = idx;
        bm_wdata = init_word;
        sm_we    = (idx_lo == 6'd63) || idx_last;
        sm_waddr = SAW'(idx >> 6);
        sm_wdata = sum_init;
      end
      S_AWORD: begin
        bm_we = whit;
      end
      S_ASUM: begin
        bm_raddr = WAW'({sidx, sb});
        sm_raddr = SAW'(sidx + 1'b1);
      end
      S_AHIT: begin
        bm_we = 1'b1;
      end
      S_FWORD: begin
        bm_we    = fbit;
        bm_wdata = clr_word;
      end
      S_SUMRD: begin
        sm_we    = 1'b1;
        sm_wdata = sum_set ? (sm_rdata | (64'(full) << wbit))
                           : (sm_rdata & ~(64'd1 << wbit));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      idx    <= '0;
      acc    <= '0;
      eff    <= '0;
      report <= 1'b0;
      done   <= 1'b0;
      count  <= CW'(NUM_FRAMES);
      first  <= 1'b0;
      sidx   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op <= request.opcode;
            response.page_address <= '0;
            response.status       <= ST_OK;
            response.free_count   <= 19'(count);
            case (request.opcode)
              OP_INIT: begin
                eff    <= eff_now;
                idx    <= '0;
                acc    <= '0;
                report <= 1'b1;
                state  <= S_CLEAR;
              end
              OP_ALLOC: begin
                if (eff_now == CW'(NUM_FRAMES)) begin
                  response.status <= ST_NO_FREE;
                  done            <= 1'b1;
                end else begin
                  frame <= FRW'(eff_now);
                  wreg  <= WAW'(eff_now >> 6);
                  state <= S_AWORD;
                end
              end
              OP_FREE: begin
                if (!free_ok) begin
                  response.status <= ST_BAD;
                  done            <= 1'b1;
                end else begin
                  frame <= FRW'(free_frame);
                  wreg  <= WAW'(free_frame >> 6);
                  state <= S_FWORD;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_CLEAR: begin
          if ((idx_lo == 6'd63) || idx_last) begin
            acc <= '0;
          end else begin
            acc <= acc | (64'(init_full) << idx_lo);
          end
          if (idx_last) begin
            count                 <= CW'(NUM_FRAMES) - eff;
            response.page_address <= '0;
            response.status       <= ST_OK;
            response.free_count   <= 19'(CW'(NUM_FRAMES) - eff);
            done                  <= report;
            report                <= 1'b0;
            state                 <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_AWORD: begin
          if (whit) begin
            frame   <= {wreg, wb};
            full    <= &set_word;
            sum_set <= 1'b1;
            state   <= S_SUMRD;
          end else begin
            sidx  <= SAW'(wreg >> 6);
            first <= 1'b1;
            state <= S_ASUM;
          end
        end
        S_ASUM: begin
          first <= 1'b0;
          if (shit) begin
            wreg  <= WAW'({sidx, sb});
            state <= S_AHIT;
          end else if (sidx == SAW'(SW - 1)) begin
            response.status <= ST_NO_FREE;
            done            <= 1'b1;
            state           <= S_IDLE;
          end else begin
            sidx <= SAW'(sidx + 1'b1);
          end
        end
        S_AHIT: begin
          frame   <= {wreg, wb};
          full    <= &set_word;
          sum_set <= 1'b1;
          state   <= S_SUMRD;
        end
        S_FWORD: begin
          if (fbit) begin
            sum_set <= 1'b0;
            state   <= S_SUMRD;
          end else begin
            response.status <= ST_BAD;
            done            <= 1'b1;
            state           <= S_IDLE;
          end
        end
        S_SUMRD: begin
          count                 <= count_upd;
          response.free_count   <= 19'(count_upd);
          response.status       <= ST_OK;
          response.page_address <= (op == OP_ALLOC) ? 30'({frame, 12'd0}) : 30'd0;
          done                  <= 1'b1;
          state                 <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start))
    else $error("result beat without a command");

  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted command neither started nor answered");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(NUM_FRAMES))
    else $error("free count above frame total");

  a_addr_ok: assert property (@(posedge clk) disable iff (rst)
    done && response.page_address != 30'd0 |-> response.status == ST_OK)
    else $error("address returned with error status");

endmodule

[rtl/pfba_ram.sv]
`timescale 1ns / 1ps
module pfba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/pfba_cfg.sv]
`timescale 1ns / 1ps
module pfba_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [18:0] reserved_frames
);
  import pfba_pkg::*;

  logic wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_frames <= '0;
    end else if (wr && paddr[2] == REG_RESERVED) begin
      reserved_frames <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_RESERVED) begin
      prdata = {{(32-CFG_W){1'b0}}, reserved_frames};
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
  import pfba_pkg::*;

  localparam int NUM_FRAMES = 262144;
  localparam int NUM_WORDS  = NUM_FRAMES / 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  class frame_alloc_scoreboard;
    logic [63:0] used_map [NUM_WORDS];
    int unsigned free_total;
    int unsigned boundary;
    int unsigned live_frames [$];
    rsp_t        expected_q [$];
    int          errors;

    function new();
      foreach (used_map[w]) used_map[w] = '0;
      free_total = NUM_FRAMES;
      boundary   = 0;
      errors     = 0;
    endfunction

    function void set_reserved(logic [31:0] v);
      boundary = (v[18:0] > NUM_FRAMES) ? NUM_FRAMES : v[18:0];
    endfunction

    function int unsigned lowest_free(int unsigned from);
      logic [63:0] avail;
      if (from >= NUM_FRAMES) return NUM_FRAMES;
      for (int unsigned w = from / 64; w < NUM_WORDS; w++) begin
        avail = ~used_map[w];
        if (w == from / 64) avail &= ~((64'd1 << (from % 64)) - 64'd1);
        if (avail != '0) begin
          for (int b = 0; b < 64; b++) begin
            if (avail[b]) return w * 64 + b;
          end
        end
      end
      return NUM_FRAMES;
    endfunction

    function void note_request(req_t r);
      rsp_t        e;
      int unsigned f;
      logic [35:0] fr;
      e = '0;
      case (r.opcode)
        OP_INIT: begin
          for (int unsigned w = 0; w < NUM_WORDS; w++) begin
            if (w * 64 + 64 <= boundary) used_map[w] = '1;
            else if (w * 64 >= boundary) used_map[w] = '0;
            else used_map[w] = (64'd1 << (boundary - w * 64)) - 64'd1;
          end
          free_total = NUM_FRAMES - boundary;
          live_frames.delete();
        end
        OP_ALLOC: begin
          f = lowest_free(boundary);
          if (f < NUM_FRAMES) begin
            used_map[f / 64][f % 64] = 1'b1;
            free_total--;
            e.page_address = 30'(f << PAGE_SHIFT);
            live_frames.push_back(f);
          end else begin
            e.status = ST_NO_FREE;
          end
        end
        OP_FREE: begin
          fr = r.free_address[47:PAGE_SHIFT];
          if (fr < NUM_FRAMES && used_map[fr / 64][fr % 64]) begin
            f = 32'(fr);
            used_map[f / 64][f % 64] = 1'b0;
            free_total++;
            for (int i = 0; i < live_frames.size(); i++) begin
              if (live_frames[i] == f) begin
                live_frames.delete(i);
                break;
              end
            end
          end else begin
            e.status = ST_BAD;
          end
        end
        default: ;
      endcase
      e.free_count = 19'(free_total);
      expected_q.push_back(e);
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: page_address %0h status %0d free_count %0d",
               got.page_address, got.status, got.free_count);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.page_address !== e.page_address) begin
        $error("page_address: expected %0h, got %0h", e.page_address, got.page_address);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
      if (got.free_count !== e.free_count) begin
        $error("free_count: expected %0d, got %0d", e.free_count, got.free_count);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        request;
  logic        done;
  rsp_t        response;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  frame_alloc_scoreboard sb;
  bit no_gaps;

  page_frame_bitmap_allocator #(.NUM_FRAMES(NUM_FRAMES)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .response(response), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_result(response);
  end

  task automatic issue(input logic [1:0] op, input logic [47:0] addr);
    req_t        r;
    int unsigned gap;
    r.opcode       = op;
    r.free_address = addr;
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    sb.note_request(r);
    if (no_gaps) gap = 0;
    else if ($urandom_range(0, 19) == 0) gap = $urandom_range(20, 120);
    else gap = $urandom_range(0, 2);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop start and let every outstanding beat come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0 || busy);
  endtask

  task automatic write_reserved(input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_RESERVED, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reserved(v);
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned f;
    logic [47:0] noise;
    noise = 48'({$urandom, $urandom});
    pick  = $urandom_range(0, 99);
    if (pick < 45 || (pick < 80 && sb.live_frames.size() == 0)) begin
      issue(OP_ALLOC, noise);
    end else if (pick < 80) begin
      f = sb.live_frames[$urandom_range(0, sb.live_frames.size() - 1)];
      issue(OP_FREE, (48'(f) << PAGE_SHIFT) | 48'(noise[11:0]));
    end else if (pick < 91) begin
      if (pick < 85 && sb.boundary > 0) f = $urandom_range(0, sb.boundary - 1);
      else f = $urandom_range(0, NUM_FRAMES - 1);
      issue(OP_FREE, (48'(f) << PAGE_SHIFT) | 48'(noise[11:0]));
    end else if (pick < 95) begin
      issue(OP_FREE, noise);
    end else if (pick < 97) begin
      issue(OP_UNUSED, noise);
    end else begin
      issue(OP_INIT, noise);
    end
  endtask

  initial begin
    logic [31:0] phase_res [6];
    bit          phase_init [6];
    sb      = new();
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    no_gaps = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    drain();

    write_reserved(32'd0);
    issue(OP_ALLOC, 48'h0);
    issue(OP_ALLOC, 48'hFFFF_FFFF_FFFF);
    issue(OP_FREE, 48'h0000_0000_0FFF);
    issue(OP_FREE, 48'h0);
    issue(OP_FREE, 48'hFFFF_FFFF_FFFF);
    issue(OP_FREE, 48'h0000_4000_0000);
    issue(OP_FREE, 48'h0000_3FFF_F000);
    issue(OP_UNUSED, 48'hA5A5_5A5A_F0F0);
    issue(OP_ALLOC, 48'h0);
    issue(OP_INIT, 48'hFFFF_FFFF_FFFF);
    drain();
    write_reserved(32'd262144);
    issue(OP_INIT, 48'h0);
    issue(OP_ALLOC, 48'h0);
    issue(OP_FREE, 48'h0000_0000_5123);
    issue(OP_ALLOC, 48'h0);
    drain();
    // upper bus bits dropped; 19-bit maximum lies beyond the frame count
    write_reserved(32'hFFFF_FFFF);
    issue(OP_INIT, 48'h5555_5555_5555);
    issue(OP_ALLOC, 48'hAAAA_AAAA_AAAA);
    drain();
    write_reserved(32'd262143);
    issue(OP_INIT, 48'h0);
    issue(OP_ALLOC, 48'h0);
    issue(OP_ALLOC, 48'h0);
    issue(OP_FREE, 48'h0000_3FFF_FABC);
    issue(OP_FREE, 48'h0);
    issue(OP_ALLOC, 48'h0);
    drain();

    phase_res  = '{32'd0, 32'd262080, 32'd262140, 32'($urandom_range(1, 262143)),
                   32'd100, 32'h0007_FFFF};
    phase_init = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    for (int p = 0; p < 6; p++) begin
      write_reserved(phase_res[p]);
      no_gaps = (p == 2);
      if (phase_init[p]) issue(OP_INIT, 48'({$urandom, $urandom}));
      for (int i = 0; i < 150; i++) begin
        if (i == 75) drain();
        random_item();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
